### hw/rtl/cwm_pkg.sv
// shared constants, codes, types and the output scaling function of the current window monitor
package cwm_pkg;

	// field and register widths
	localparam int unsigned SAMPLE_W  = 10;
	localparam int unsigned SUM_W     = 14;
	localparam int unsigned VALUE_W   = 10;
	localparam int unsigned BUDGET_W  = 8;
	localparam int unsigned CODE_W    = 2;
	localparam int unsigned IDX_W     = 3;
	localparam int unsigned DATA_W    = 10;
	localparam int unsigned SCALE_W   = 20;

	// default words per averaging group
	localparam int unsigned GROUP_SIZE_DEF = 10;

	// full scale of the adc and of the scaled output
	localparam logic [VALUE_W-1:0] ADC_MAX   = 10'd1023;
	localparam logic [SCALE_W-1:0] OUT_SCALE = 20'd1000;

	// register reset values
	localparam logic [VALUE_W-1:0] HIGH_RESET = 10'd50;
	localparam logic [VALUE_W-1:0] LOW_RESET  = 10'd10;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_OFFSET = 3'd0,
		REG_AUTO   = 3'd1,
		REG_BUDGET = 3'd2,
		REG_HIGH   = 3'd3,
		REG_LOW    = 3'd4
	} reg_idx_t;

	// direction of the group average relative to the offset
	typedef enum logic [CODE_W-1:0] {
		DIR_ZERO  = 2'd0,
		DIR_BELOW = 2'd1,
		DIR_ABOVE = 2'd2
	} dir_t;

	// measurement status carried with each result
	typedef enum logic [CODE_W-1:0] {
		ST_RUNNING  = 2'd0,
		ST_FAULT    = 2'd1,
		ST_FINISHED = 2'd2
	} status_t;

	// control flags that travel down the pipeline with each word
	typedef struct packed {
		logic restart;
		logic stop;
		logic grp;
	} tok_t;

	// floor(d * 1000 / 1023): divide by 2^10 - 1 through a folded shift
	function automatic logic [VALUE_W-1:0] scale_dist(input logic [VALUE_W-1:0] d);
		logic [SCALE_W-1:0] x;
		logic [SCALE_W-1:0] y;
		x = SCALE_W'(d) * OUT_SCALE;
		y = x + (x >> VALUE_W) + SCALE_W'(1);
		return y[SCALE_W-1:VALUE_W];
	endfunction

endpackage

### hw/rtl/cwm_if.sv
// stream interfaces for sample words in and result words out
interface cwm_in_if;
	logic                          valid;
	logic                          ready;
	logic [cwm_pkg::SAMPLE_W-1:0]  sample;
	logic                          restart;
	logic                          stop;

	modport source (output valid, sample, restart, stop, input ready);
	modport sink (input valid, sample, restart, stop, output ready);
endinterface

interface cwm_out_if;
	logic                          valid;
	logic                          ready;
	logic [cwm_pkg::VALUE_W-1:0]   present_value;
	logic [cwm_pkg::VALUE_W-1:0]   near_extreme;
	logic [cwm_pkg::VALUE_W-1:0]   far_extreme;
	logic [cwm_pkg::CODE_W-1:0]    direction;
	logic [cwm_pkg::CODE_W-1:0]    status;

	modport source (output valid, present_value, near_extreme, far_extreme, direction, status,
		input ready);
	modport sink (input valid, present_value, near_extreme, far_extreme, direction, status,
		output ready);
endinterface

### hw/rtl/current_window_monitor.sv
// top level of the current window monitor: registers, extremes, scaling and status
// One sample word can be accepted every clock cycle unless a result left waiting at the output
// holds the whole pipeline; input ready follows output ready while a result is pending. Until
// the run ends, every GROUP_SIZE words (stop words excluded) form a group whose floor average
// yields one result word, and a stop word one of its own. A result reaches the output register
// through four stages: accumulate, reciprocal-multiply average, running extremes and offset
// distances, then scaling by 1000/1023 with the window and countdown check. The user must
// write configuration through the plain write port while no word is in flight; not enforced.
module current_window_monitor #(
	parameter int unsigned GROUP_SIZE = cwm_pkg::GROUP_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	cwm_in_if.sink                       samples,
	cwm_out_if.source                    results,
	input  logic                         wr_en,
	input  logic [cwm_pkg::IDX_W-1:0]    wr_index,
	input  logic [cwm_pkg::DATA_W-1:0]   wr_data
);

	logic                          adv;
	logic                          take;

	logic [cwm_pkg::VALUE_W-1:0]   offset_q;
	logic                          auto_q;
	logic [cwm_pkg::BUDGET_W-1:0]  budget_q;
	logic [cwm_pkg::VALUE_W-1:0]   high_q;
	logic [cwm_pkg::VALUE_W-1:0]   low_q;

	logic                          v_s2;
	cwm_pkg::tok_t                 tok_s2;
	logic [cwm_pkg::VALUE_W-1:0]   avg_s2;

	logic [cwm_pkg::VALUE_W-1:0]   lo_q;
	logic [cwm_pkg::VALUE_W-1:0]   hi_q;
	logic [cwm_pkg::VALUE_W-1:0]   lo_base;
	logic [cwm_pkg::VALUE_W-1:0]   hi_base;
	logic [cwm_pkg::VALUE_W-1:0]   lo_new;
	logic [cwm_pkg::VALUE_W-1:0]   hi_new;
	cwm_pkg::dir_t                 dir_c;
	logic [cwm_pkg::VALUE_W-1:0]   pres_d;
	logic [cwm_pkg::VALUE_W-1:0]   near_d;
	logic [cwm_pkg::VALUE_W-1:0]   far_d;

	logic                          v_s3;
	cwm_pkg::tok_t                 tok_s3;
	cwm_pkg::dir_t                 dir_s3;
	logic [cwm_pkg::VALUE_W-1:0]   pres_d_s3;
	logic [cwm_pkg::VALUE_W-1:0]   near_d_s3;
	logic [cwm_pkg::VALUE_W-1:0]   far_d_s3;

	logic [cwm_pkg::VALUE_W-1:0]   pres_sc;
	logic [cwm_pkg::VALUE_W-1:0]   near_sc;
	logic [cwm_pkg::VALUE_W-1:0]   far_sc;
	logic                          ended_q;
	logic [cwm_pkg::BUDGET_W-1:0]  left_q;
	logic                          e_base;
	logic [cwm_pkg::BUDGET_W-1:0]  left_base;
	logic                          emit;
	cwm_pkg::status_t              stat_c;
	logic                          end_nxt;
	logic [cwm_pkg::BUDGET_W-1:0]  left_nxt;

	logic                          res_valid_q;
	logic [cwm_pkg::VALUE_W-1:0]   res_pres_q;
	logic [cwm_pkg::VALUE_W-1:0]   res_near_q;
	logic [cwm_pkg::VALUE_W-1:0]   res_far_q;
	cwm_pkg::dir_t                 res_dir_q;
	cwm_pkg::status_t              res_stat_q;

	// whole pipeline moves unless a result is held at the output
	assign adv           = !res_valid_q || results.ready;
	assign take          = samples.valid && adv;
	assign samples.ready = adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			auto_q   <= 1'b0;
			budget_q <= '0;
			high_q   <= cwm_pkg::HIGH_RESET;
			low_q    <= cwm_pkg::LOW_RESET;
		end else if (wr_en) begin
			unique case (cwm_pkg::reg_idx_t'(wr_index))
				cwm_pkg::REG_OFFSET: offset_q <= wr_data[cwm_pkg::VALUE_W-1:0];
				cwm_pkg::REG_AUTO:   auto_q   <= wr_data[0];
				cwm_pkg::REG_BUDGET: budget_q <= wr_data[cwm_pkg::BUDGET_W-1:0];
				cwm_pkg::REG_HIGH:   high_q   <= wr_data[cwm_pkg::VALUE_W-1:0];
				cwm_pkg::REG_LOW:    low_q    <= wr_data[cwm_pkg::VALUE_W-1:0];
				default: ;
			endcase
		end
	end

	// accumulate and average
	cwm_accum #(
		.GROUP_SIZE (GROUP_SIZE)
	) u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.take    (take),
		.sample  (samples.sample),
		.restart (samples.restart),
		.stop    (samples.stop),
		.v_s2    (v_s2),
		.tok_s2  (tok_s2),
		.avg_s2  (avg_s2)
	);

	// running extremes, then distances from the offset
	always_comb begin
		lo_base = tok_s2.restart ? cwm_pkg::ADC_MAX : lo_q;
		hi_base = tok_s2.restart ? '0 : hi_q;
		lo_new  = (tok_s2.grp && (avg_s2 < lo_base)) ? avg_s2 : lo_base;
		hi_new  = (tok_s2.grp && (avg_s2 > hi_base)) ? avg_s2 : hi_base;
		if (offset_q > avg_s2) begin
			dir_c  = cwm_pkg::DIR_BELOW;
			pres_d = offset_q - avg_s2;
			near_d = (offset_q > hi_new) ? offset_q - hi_new : '0;
			far_d  = (offset_q > lo_new) ? offset_q - lo_new : '0;
		end else if (avg_s2 > offset_q) begin
			dir_c  = cwm_pkg::DIR_ABOVE;
			pres_d = avg_s2 - offset_q;
			near_d = (lo_new > offset_q) ? lo_new - offset_q : '0;
			far_d  = (hi_new > offset_q) ? hi_new - offset_q : '0;
		end else begin
			dir_c  = cwm_pkg::DIR_ZERO;
			pres_d = '0;
			near_d = '0;
			far_d  = '0;
		end
	end

	// scaling, window check and countdown
	always_comb begin
		pres_sc   = cwm_pkg::scale_dist(pres_d_s3);
		near_sc   = cwm_pkg::scale_dist(near_d_s3);
		far_sc    = cwm_pkg::scale_dist(far_d_s3);
		e_base    = tok_s3.restart ? 1'b0 : ended_q;
		left_base = tok_s3.restart ? budget_q : left_q;
		emit      = 1'b0;
		stat_c    = cwm_pkg::ST_RUNNING;
		end_nxt   = e_base;
		left_nxt  = left_base;
		priority if (e_base) begin
			emit = 1'b0;
		end else if (tok_s3.stop) begin
			emit    = 1'b1;
			stat_c  = cwm_pkg::ST_FINISHED;
			end_nxt = 1'b1;
		end else if (tok_s3.grp) begin
			emit = 1'b1;
			if (auto_q) begin
				priority if ((far_sc > high_q) || (far_sc < low_q)) begin
					stat_c  = cwm_pkg::ST_FAULT;
					end_nxt = 1'b1;
				end else if (left_base != '0) begin
					left_nxt = left_base - cwm_pkg::BUDGET_W'(1);
				end else begin
					stat_c  = cwm_pkg::ST_FINISHED;
					end_nxt = 1'b1;
				end
			end
		end
	end

	// control state of the later stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q        <= cwm_pkg::ADC_MAX;
			hi_q        <= '0;
			v_s3        <= 1'b0;
			ended_q     <= 1'b0;
			left_q      <= '0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			if (v_s2) begin
				lo_q <= lo_new;
				hi_q <= hi_new;
			end
			v_s3 <= v_s2;
			if (v_s3) begin
				ended_q <= end_nxt;
				left_q  <= left_nxt;
			end
			res_valid_q <= v_s3 && emit;
		end
	end

	// stage and result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s3    <= tok_s2;
			dir_s3    <= dir_c;
			pres_d_s3 <= pres_d;
			near_d_s3 <= near_d;
			far_d_s3  <= far_d;
			if (tok_s3.stop) begin
				res_pres_q <= '0;
				res_near_q <= '0;
				res_far_q  <= '0;
				res_dir_q  <= cwm_pkg::DIR_ZERO;
			end else begin
				res_pres_q <= pres_sc;
				res_near_q <= near_sc;
				res_far_q  <= far_sc;
				res_dir_q  <= dir_s3;
			end
			res_stat_q <= stat_c;
		end
	end

	// result word
	assign results.valid         = res_valid_q;
	assign results.present_value = res_pres_q;
	assign results.near_extreme  = res_near_q;
	assign results.far_extreme   = res_far_q;
	assign results.direction     = res_dir_q;
	assign results.status        = res_stat_q;

`ifndef SYNTHESIS
	// scaled values stay within output full scale
	a_full_scale: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.present_value <= 10'd1000) &&
			(results.near_extreme <= 10'd1000) && (results.far_extreme <= 10'd1000))
		else $error("scaled value above full scale");

	// average on the offset gives zero distances
	a_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.direction == cwm_pkg::DIR_ZERO) |->
			(results.present_value == '0) && (results.near_extreme == '0) &&
			(results.far_extreme == '0))
		else $error("non-zero distance with zero direction");

	// near extreme never lies beyond the far extreme
	a_near_far: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.near_extreme <= results.far_extreme)
		else $error("near extreme above far extreme");

	// window faults only in auto mode
	a_fault_auto: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !auto_q |-> results.status != cwm_pkg::ST_FAULT)
		else $error("fault status with auto mode off");
`endif

endmodule

### hw/rtl/cwm_accum.sv
// group accumulator and reciprocal-multiply averaging stages
module cwm_accum #(
	parameter int unsigned GROUP_SIZE = cwm_pkg::GROUP_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          take,
	input  logic [cwm_pkg::SAMPLE_W-1:0]  sample,
	input  logic                          restart,
	input  logic                          stop,
	output logic                          v_s2,
	output cwm_pkg::tok_t                 tok_s2,
	output logic [cwm_pkg::VALUE_W-1:0]   avg_s2
);

	localparam int unsigned CNT_W      = $clog2(GROUP_SIZE + 1);
	localparam int unsigned DIV_SHIFT  = cwm_pkg::SUM_W + 5;
	localparam int unsigned DIV_MUL_W  = DIV_SHIFT + 1;
	localparam logic [DIV_MUL_W-1:0] DIV_MUL =
		DIV_MUL_W'((2 ** DIV_SHIFT + GROUP_SIZE - 1) / GROUP_SIZE);
	localparam int unsigned PROD_W     = cwm_pkg::SUM_W + DIV_MUL_W;
	localparam int unsigned QUO_W      = PROD_W - DIV_SHIFT;

	logic [cwm_pkg::SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [cwm_pkg::SUM_W-1:0]   base_sum;
	logic [CNT_W-1:0]            base_cnt;
	logic [cwm_pkg::SUM_W-1:0]   acc_sum;
	logic [CNT_W-1:0]            acc_cnt;
	logic                        done;
	logic                        v_s1;
	cwm_pkg::tok_t               tok_s1;
	logic [cwm_pkg::SUM_W-1:0]   sum_s1;
	logic [PROD_W-1:0]           prod;
	logic [QUO_W-1:0]            quo;
	logic [cwm_pkg::VALUE_W-1:0] avg_div;

	// running sum of the group, cleared first on restart
	always_comb begin
		base_sum = restart ? '0 : sum_q;
		base_cnt = restart ? '0 : cnt_q;
		acc_sum  = base_sum + cwm_pkg::SUM_W'(sample);
		acc_cnt  = base_cnt + CNT_W'(1);
		done     = !stop && (acc_cnt == CNT_W'(GROUP_SIZE));
	end

	// floor division by the group size through an exact reciprocal, clamped to adc range
	always_comb begin
		prod = PROD_W'(sum_s1) * PROD_W'(DIV_MUL);
		quo  = prod[PROD_W-1:DIV_SHIFT];
		if (quo > QUO_W'(cwm_pkg::ADC_MAX)) begin
			avg_div = cwm_pkg::ADC_MAX;
		end else begin
			avg_div = quo[cwm_pkg::VALUE_W-1:0];
		end
	end

	// accumulator state and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (take) begin
				if (stop) begin
					sum_q <= base_sum;
					cnt_q <= base_cnt;
				end else if (done) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= acc_sum;
					cnt_q <= acc_cnt;
				end
			end
			if (adv) begin
				v_s1 <= take;
				v_s2 <= v_s1;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s1.restart <= restart;
			tok_s1.stop    <= stop;
			tok_s1.grp     <= done;
			sum_s1         <= acc_sum;
			tok_s2         <= tok_s1;
			avg_s2         <= avg_div;
		end
	end

`ifndef SYNTHESIS
	// the stored count never reaches a full group
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(GROUP_SIZE))
		else $error("group count out of range");

	// a stop word never closes a group
	a_stop_no_grp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !(tok_s1.stop && tok_s1.grp))
		else $error("stop word marked as group end");

	// a stop word without restart leaves the sum untouched
	a_stop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		take && stop && !restart |=> sum_q == $past(sum_q))
		else $error("stop word changed the group sum");
`endif

endmodule

### dv/current_window_monitor_tb.sv
// self-checking testbench of the current window monitor: group readings predicted and compared
module current_window_monitor_tb;

	import cwm_pkg::*;

	localparam int unsigned GROUP = GROUP_SIZE_DEF;

	// one result word as the block presents it
	typedef struct packed {
		logic [VALUE_W-1:0] present;
		logic [VALUE_W-1:0] near;
		logic [VALUE_W-1:0] far;
		dir_t               dir;
		status_t            status;
	} reading_t;

	// tracks the measurement state and holds the readings still due from the block
	class reading_board;
		reading_t due_readings[$];
		int unsigned errors;

		logic [VALUE_W-1:0]  offset_q;
		logic                auto_q;
		logic [BUDGET_W-1:0] budget_q;
		logic [VALUE_W-1:0]  high_q;
		logic [VALUE_W-1:0]  low_q;

		int unsigned         count_q;
		logic [SUM_W-1:0]    sum_q;
		int unsigned         lowest_q;
		int unsigned         highest_q;
		logic [BUDGET_W-1:0] left_q;
		bit                  ended_q;

		function new();
			errors   = 0;
			offset_q = '0;
			auto_q   = 1'b0;
			budget_q = '0;
			high_q   = HIGH_RESET;
			low_q    = LOW_RESET;
			clear_measurement();
		endfunction

		function void clear_measurement();
			count_q   = 0;
			sum_q     = '0;
			lowest_q  = ADC_MAX;
			highest_q = 0;
			left_q    = budget_q;
			ended_q   = 1'b0;
		endfunction

		// floor of d * 1000 / 1023
		function logic [VALUE_W-1:0] to_milli(int unsigned d);
			return VALUE_W'((d * int'(OUT_SCALE)) / int'(ADC_MAX));
		endfunction

		// how far a lies above b, zero when it does not
		function int unsigned above(int unsigned a, int unsigned b);
			return (a > b) ? a - b : 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [DATA_W-1:0] data);
			case (idx)
				REG_OFFSET: offset_q = data[VALUE_W-1:0];
				REG_AUTO:   auto_q   = data[0];
				REG_BUDGET: budget_q = data[BUDGET_W-1:0];
				REG_HIGH:   high_q   = data[VALUE_W-1:0];
				REG_LOW:    low_q    = data[VALUE_W-1:0];
				default: ;
			endcase
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		// predict what one accepted sample word causes
		function void take_word(logic [SAMPLE_W-1:0] s, logic r, logic st);
			reading_t    rd;
			int unsigned avg;
			int unsigned off;
			rd = '0;
			if (r)
				clear_measurement();
			if (ended_q)
				return;
			// operator stop ends the run with an empty finished reading
			if (st) begin
				ended_q   = 1'b1;
				rd.dir    = DIR_ZERO;
				rd.status = ST_FINISHED;
				due_readings.push_back(rd);
				return;
			end
			sum_q = sum_q + SUM_W'(s);
			count_q++;
			if (count_q < GROUP)
				return;
			avg = sum_q / GROUP;
			if (avg > ADC_MAX)
				avg = ADC_MAX;
			sum_q   = '0;
			count_q = 0;
			if (avg > highest_q)
				highest_q = avg;
			if (avg < lowest_q)
				lowest_q = avg;
			off = offset_q;
			// distances from the offset, near side saturating at zero
			if (off > avg) begin
				rd.dir     = DIR_BELOW;
				rd.present = to_milli(off - avg);
				rd.near    = to_milli(above(off, highest_q));
				rd.far     = to_milli(above(off, lowest_q));
			end else if (avg > off) begin
				rd.dir     = DIR_ABOVE;
				rd.present = to_milli(avg - off);
				rd.near    = to_milli(above(lowest_q, off));
				rd.far     = to_milli(above(highest_q, off));
			end else begin
				rd.dir = DIR_ZERO;
			end
			// window trip and reading countdown
			rd.status = ST_RUNNING;
			if (auto_q) begin
				if (rd.far > high_q || rd.far < low_q) begin
					rd.status = ST_FAULT;
					ended_q   = 1'b1;
				end else if (left_q != 0) begin
					left_q--;
				end else begin
					rd.status = ST_FINISHED;
					ended_q   = 1'b1;
				end
			end
			due_readings.push_back(rd);
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got)
				flag($sformatf("mismatch on %s: expected %0d, got %0d", name, want, got));
		endfunction

		function void check_reading(reading_t got);
			reading_t want;
			if (due_readings.size() == 0) begin
				flag($sformatf("result word with nothing due: present %0d near %0d far %0d dir %0d status %0d",
					got.present, got.near, got.far, got.dir, got.status));
				return;
			end
			want = due_readings.pop_front();
			check_field("present_value", want.present, got.present);
			check_field("near_extreme", want.near, got.near);
			check_field("far_extreme", want.far, got.far);
			check_field("direction", want.dir, got.dir);
			check_field("status", want.status, got.status);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_index;
	logic [DATA_W-1:0]   wr_data;

	cwm_in_if  samples_if ();
	cwm_out_if results_if ();

	reading_board board;
	int unsigned  live_words;
	bit           src_idle_on;
	bit           snk_idle_on;

	current_window_monitor #(
		.GROUP_SIZE(GROUP)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples_if),
		.results  (results_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard limit on the run
	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// offer one word, wait for it to be taken and note it
	task automatic send_word(logic [SAMPLE_W-1:0] s, logic r, logic st);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			samples_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		samples_if.valid   <= 1'b1;
		samples_if.sample  <= s;
		samples_if.restart <= r;
		samples_if.stop    <= st;
		@(posedge clk);
		while (!samples_if.ready)
			@(posedge clk);
		if (r || !board.ended_q)
			live_words++;
		board.take_word(s, r, st);
	endtask

	// one averaging group of shaped content, with the odd stray restart or stop
	task automatic send_group(bit lead);
		int unsigned mode;
		int unsigned base;
		int          v;
		bit          r;
		bit          st;
		mode = $urandom_range(0, 2);
		case ($urandom_range(0, 5))
			0:       base = 0;
			1:       base = ADC_MAX;
			2:       base = board.offset_q;
			default: base = $urandom_range(0, ADC_MAX);
		endcase
		for (int i = 0; i < GROUP; i++) begin
			r  = (lead && i == 0) || ($urandom_range(0, 99) == 0);
			st = ($urandom_range(0, 69) == 0);
			if (board.ended_q && !r)
				break;
			case (mode)
				0: v = base;
				1: begin
					v = int'(base) + int'($urandom_range(0, 16)) - 8;
					if (v < 0)
						v = 0;
					if (v > int'(ADC_MAX))
						v = ADC_MAX;
				end
				default: v = $urandom_range(0, ADC_MAX);
			endcase
			send_word(v[SAMPLE_W-1:0], r, st);
		end
	endtask

	// random traffic until the given number of words has had an effect
	task automatic run_phase(int unsigned words);
		int unsigned target;
		target = live_words + words;
		send_group(1'b1);
		while (live_words < target) begin
			if (board.ended_q) begin
				if ($urandom_range(0, 7) == 0)
					send_word($urandom_range(0, ADC_MAX), 1'b0, 1'($urandom_range(0, 1)));
				send_group(1'b1);
			end else begin
				send_group(1'b0);
			end
		end
	endtask

	// hold the input until every due reading is out and the pipeline is empty
	task automatic drain();
		samples_if.valid <= 1'b0;
		while (board.due_readings.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(int unsigned off, int unsigned auto_on, int unsigned budget,
		int unsigned high, int unsigned low);
		logic [DATA_W-1:0] vals [5];
		vals[0] = DATA_W'(off);
		vals[1] = DATA_W'(auto_on);
		vals[2] = DATA_W'(budget);
		vals[3] = DATA_W'(high);
		vals[4] = DATA_W'(low);
		for (int i = 0; i < 5; i++) begin
			wr_en    <= 1'b1;
			wr_index <= IDX_W'(i);
			wr_data  <= vals[i];
			@(posedge clk);
			board.write_reg(reg_idx_t'(i), vals[i]);
		end
		wr_en <= 1'b0;
	endtask

	// result side: check every taken word, stall in bursts and once for a long stretch
	initial begin
		int unsigned hold;
		int unsigned idle;
		int unsigned seen;
		bit          held_once;
		reading_t    got;
		hold      = 0;
		idle      = 0;
		seen      = 0;
		held_once = 1'b0;
		results_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (results_if.valid && results_if.ready) begin
				got.present = results_if.present_value;
				got.near    = results_if.near_extreme;
				got.far     = results_if.far_extreme;
				got.dir     = dir_t'(results_if.direction);
				got.status  = status_t'(results_if.status);
				board.check_reading(got);
				seen++;
			end
			if (!held_once && seen == 40) begin
				hold      = 120;
				held_once = 1'b1;
			end
			if (hold != 0) begin
				hold--;
				results_if.ready <= 1'b0;
			end else if (idle != 0) begin
				idle--;
				results_if.ready <= 1'b0;
			end else if (snk_idle_on && $urandom_range(0, 4) == 0) begin
				idle = $urandom_range(0, 3);
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= 1'b1;
			end
		end
	end

	// stimulus
	initial begin
		board       = new();
		live_words  = 0;
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		arst_n      = 1'b0;
		wr_en       = 1'b0;
		wr_index    = '0;
		wr_data     = '0;
		samples_if.valid   = 1'b0;
		samples_if.sample  = '0;
		samples_if.restart = 1'b0;
		samples_if.stop    = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full-scale group, stop, words while ended, restart with stop, group on the offset
		send_word(ADC_MAX, 1'b1, 1'b0);
		repeat (GROUP - 1) send_word(ADC_MAX, 1'b0, 1'b0);
		send_word('0, 1'b0, 1'b1);
		send_word(ADC_MAX, 1'b0, 1'b1);
		send_word('0, 1'b0, 1'b0);
		send_word('0, 1'b1, 1'b1);
		send_word('0, 1'b1, 1'b0);
		repeat (GROUP - 1) send_word('0, 1'b0, 1'b0);

		// phases of settings, extremes first, then random ones
		for (int p = 0; p < 9; p++) begin
			drain();
			src_idle_on = (p != 2);
			snk_idle_on = (p != 4);
			case (p)
				0: ;
				1: configure(512, 0, 0, 50, 10);
				2: configure(0, 1, 255, 1000, 0);
				3: configure(ADC_MAX, 1, 0, 1000, 0);
				4: configure(300, 1, 3, 200, 20);
				5: configure(700, 1, 10, 1000, 1000);
				6: configure(511, 1, 5, 0, 0);
				default: configure($urandom_range(0, ADC_MAX), $urandom_range(0, 1),
					$urandom_range(0, 20), $urandom_range(100, 1000), $urandom_range(0, 50));
			endcase
			if (p == 8) begin
				src_idle_on = 1'b0;
				snk_idle_on = 1'b0;
			end
			run_phase(190);
		end

		drain();
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.due_readings.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/cwm_pkg.sv
hw/rtl/cwm_if.sv
hw/rtl/cwm_accum.sv
hw/rtl/current_window_monitor.sv
dv/current_window_monitor_tb.sv
